// ===== hw/rtl/qem_pkg.sv =====
// ----------------------------------------------------------------------------
// qem_pkg
// Shared types and constants of the quaternion exponential map core.
// ----------------------------------------------------------------------------
package qem_pkg;

	localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1847;
	localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

	typedef struct packed {
		logic               zero;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
	} item_t;

	typedef struct packed {
		item_t       itm;
		logic [31:0] theta;
	} norm_t;

	typedef struct packed {
		item_t              itm;
		logic [31:0]        theta;
		logic signed [31:0] sh;
		logic signed [31:0] ch;
	} trig_t;

endpackage

// ===== hw/rtl/qem_front.sv =====
// ----------------------------------------------------------------------------
// qem_front
// Accepts rotation vectors, flags the zero vector and queues items for the back end.
// ----------------------------------------------------------------------------
module qem_front #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] rot_x,
	input  logic signed [31:0] rot_y,
	input  logic signed [31:0] rot_z,
	output logic               out_valid,
	output qem_pkg::item_t     out_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	qem_pkg::item_t mem_q [DEPTH];
	logic           push;
	logic           pop;

	assign busy      = (count_q == CW'(DEPTH));
	assign push      = start && !busy;
	assign pop       = (count_q != '0);
	assign out_valid = pop;
	assign out_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q].zero <= (rot_x == '0) && (rot_y == '0) && (rot_z == '0);
			mem_q[wr_ptr_q].rx   <= rot_x;
			mem_q[wr_ptr_q].ry   <= rot_y;
			mem_q[wr_ptr_q].rz   <= rot_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_never_full: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("item queue filled up although the back end never stalls");
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n) push |=> out_valid)
		else $error("accepted item did not reach the back end");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) && !push |=> !out_valid)
		else $error("back end received an item from an empty queue");

endmodule

// ===== hw/rtl/qem_sqrt.sv =====
// ----------------------------------------------------------------------------
// qem_sqrt
// Sum of squares and a one-bit-per-stage integer square root giving theta.
// ----------------------------------------------------------------------------
module qem_sqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  qem_pkg::item_t in_item,
	output logic           out_valid,
	output qem_pkg::norm_t out_norm
);

	localparam int NSTG = 32;

	logic signed [63:0] sqx_s1, sqy_s1, sqz_s1;
	qem_pkg::item_t     item_s1;
	logic [NSTG+1:0]    vld_q;

	logic [33:0]        rem_q  [0:NSTG];
	logic [31:0]        root_q [0:NSTG];
	logic [63:0]        rad_q  [0:NSTG];
	qem_pkg::item_t     itm_q  [0:NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[NSTG:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		sqx_s1  <= in_item.rx * in_item.rx;
		sqy_s1  <= in_item.ry * in_item.ry;
		sqz_s1  <= in_item.rz * in_item.rz;
		item_s1 <= in_item;
		rad_q[0]  <= $unsigned(sqx_s1) + $unsigned(sqy_s1) + $unsigned(sqz_s1);
		rem_q[0]  <= '0;
		root_q[0] <= '0;
		itm_q[0]  <= item_s1;
	end

	for (genvar g = 0; g < NSTG; g++) begin : g_stage
		logic [35:0] cur;
		logic [35:0] trial;
		logic        ge;

		assign cur   = {rem_q[g], rad_q[g][63:62]};
		assign trial = {2'b00, root_q[g], 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk) begin
			rem_q[g+1]  <= ge ? 34'(cur - trial) : cur[33:0];
			root_q[g+1] <= {root_q[g][30:0], ge};
			rad_q[g+1]  <= {rad_q[g][61:0], 2'b00};
			itm_q[g+1]  <= itm_q[g];
		end
	end

	assign out_valid      = vld_q[NSTG+1];
	assign out_norm.itm   = itm_q[NSTG];
	assign out_norm.theta = root_q[NSTG];

endmodule

// ===== hw/rtl/qem_sincos.sv =====
// ----------------------------------------------------------------------------
// qem_sincos
// Quadrant reduction of the half angle and pipelined Horner sine and cosine.
// ----------------------------------------------------------------------------
module qem_sincos (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  qem_pkg::norm_t in_norm,
	output logic           out_valid,
	output qem_pkg::trig_t out_trig
);

	localparam int NSTEP = 9;
	localparam int LAT   = 5 + 3 * NSTEP + 2;
	localparam logic [63:0] P1 = qem_pkg::HALF_PI_Q60;
	localparam logic [63:0] P2 = qem_pkg::HALF_PI_Q60 << 1;
	localparam logic [63:0] P4 = qem_pkg::HALF_PI_Q60 << 2;
	localparam logic [63:0] RND29 = 64'd1 << 29;

	typedef struct packed {
		qem_pkg::item_t itm;
		logic [31:0]    theta;
		logic [1:0]     quad;
		logic [31:0]    x;
		logic [31:0]    x2;
	} ctx_t;

	logic [LAT-1:0] vld_q;

	logic [63:0]    h_s1, h_s2, h_s3;
	logic [1:0]     q_s2;
	logic [1:0]     q_s3;
	qem_pkg::norm_t nrm_s1, nrm_s2, nrm_s3, nrm_s4;
	logic [1:0]     q_s4;
	logic [31:0]    x_s4;

	ctx_t               hx_q   [0:NSTEP];
	logic signed [31:0] tc_q   [0:NSTEP];
	logic signed [31:0] ts_q   [0:NSTEP];

	logic [62:0]        pc_a_q [NSTEP];
	logic [62:0]        ps_a_q [NSTEP];
	logic signed [31:0] ts_a_q [NSTEP];
	ctx_t               cx_a_q [NSTEP];
	logic [32:0]        mc_b_q [NSTEP];
	logic [32:0]        ms_b_q [NSTEP];
	logic [66:0]        rc_b_q [NSTEP];
	logic [66:0]        rs_b_q [NSTEP];
	logic signed [31:0] ts_b_q [NSTEP];
	ctx_t               cx_b_q [NSTEP];

	ctx_t               cx_f1;
	logic signed [31:0] s_f1;
	logic signed [31:0] c_f1;
	logic [62:0]        sp;
	logic [63:0]        h0;
	logic [63:0]        xr;
	logic [63:0]        xx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	assign h0 = {1'b0, in_norm.theta, 31'b0};
	assign xr = h_s3 + RND29;
	assign xx = x_s4 * x_s4 + RND29;

	always_ff @(posedge clk) begin
		h_s1   <= (h0 >= P4) ? h0 - P4 : h0;
		nrm_s1 <= in_norm;
		q_s2   <= {1'b0, (h_s1 >= P2)};
		h_s2   <= (h_s1 >= P2) ? h_s1 - P2 : h_s1;
		nrm_s2 <= nrm_s1;
		q_s3   <= {q_s2[0], (h_s2 >= P1)};
		h_s3   <= (h_s2 >= P1) ? h_s2 - P1 : h_s2;
		nrm_s3 <= nrm_s2;
		x_s4   <= xr[61:30];
		q_s4   <= q_s3;
		nrm_s4 <= nrm_s3;
		hx_q[0].itm   <= nrm_s4.itm;
		hx_q[0].theta <= nrm_s4.theta;
		hx_q[0].quad  <= q_s4;
		hx_q[0].x     <= x_s4;
		hx_q[0].x2    <= xx[61:30];
		tc_q[0] <= qem_pkg::Q30_ONE;
		ts_q[0] <= qem_pkg::Q30_ONE;
	end

	for (genvar j = 0; j < NSTEP; j++) begin : g_horner
		localparam int KK = NSTEP - j;
		localparam int DC = (2 * KK - 1) * (2 * KK);
		localparam int DS = (2 * KK) * (2 * KK + 1);
		localparam logic [33:0] RC = 34'((64'd1 << 34) / DC);
		localparam logic [33:0] RS = 34'((64'd1 << 34) / DS);

		logic [32:0] qc, qs, fc, fs;
		logic [41:0] rc, rs;

		assign qc = rc_b_q[j][66:34];
		assign qs = rs_b_q[j][66:34];
		assign rc = 42'(mc_b_q[j]) - 42'(qc) * 42'(DC);
		assign rs = 42'(ms_b_q[j]) - 42'(qs) * 42'(DS);
		assign fc = (rc >= 42'(DC)) ? qc + 1'b1 : qc;
		assign fs = (rs >= 42'(DS)) ? qs + 1'b1 : qs;

		always_ff @(posedge clk) begin
			pc_a_q[j] <= hx_q[j].x2 * tc_q[j][30:0];
			ps_a_q[j] <= hx_q[j].x2 * ts_q[j][30:0];
			ts_a_q[j] <= ts_q[j];
			cx_a_q[j] <= hx_q[j];
			mc_b_q[j] <= pc_a_q[j][62:30];
			ms_b_q[j] <= ps_a_q[j][62:30];
			rc_b_q[j] <= pc_a_q[j][62:30] * RC;
			rs_b_q[j] <= ps_a_q[j][62:30] * RS;
			ts_b_q[j] <= ts_a_q[j];
			cx_b_q[j] <= cx_a_q[j];
			tc_q[j+1] <= 32'(34'h0_4000_0000 - {1'b0, fc});
			ts_q[j+1] <= (KK > 8) ? ts_b_q[j] : 32'(34'h0_4000_0000 - {1'b0, fs});
			hx_q[j+1] <= cx_b_q[j];
		end
	end

	assign sp = hx_q[NSTEP].x * ts_q[NSTEP][30:0];

	always_ff @(posedge clk) begin
		s_f1  <= sp[61:30];
		c_f1  <= tc_q[NSTEP];
		cx_f1 <= hx_q[NSTEP];
		out_trig.itm   <= cx_f1.itm;
		out_trig.theta <= cx_f1.theta;
		case (cx_f1.quad)
			2'd0: begin
				out_trig.sh <= s_f1;
				out_trig.ch <= c_f1;
			end
			2'd1: begin
				out_trig.sh <= c_f1;
				out_trig.ch <= -s_f1;
			end
			2'd2: begin
				out_trig.sh <= -s_f1;
				out_trig.ch <= -c_f1;
			end
			default: begin
				out_trig.sh <= -c_f1;
				out_trig.ch <= s_f1;
			end
		endcase
	end

	assign out_valid = vld_q[LAT-1];

endmodule

// ===== hw/rtl/qem_div.sv =====
// ----------------------------------------------------------------------------
// qem_div
// Scales the sine by each component over theta with three restoring dividers.
// ----------------------------------------------------------------------------
module qem_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  qem_pkg::trig_t     in_trig,
	output logic               done,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z
);

	localparam int NQ  = 31;
	localparam int LAT = NQ + 3;

	typedef struct packed {
		logic               zero;
		logic [31:0]        theta;
		logic signed [31:0] ch;
	} dctx_t;

	logic [LAT-1:0]     vld_q;
	logic signed [63:0] p_s1 [3];
	dctx_t              cx_s1;
	logic signed [31:0] rv [3];

	logic [31:0] rem_q [0:NQ][3];
	logic [30:0] quo_q [0:NQ][3];
	logic [62:0] mag_q [0:NQ][3];
	logic        neg_q [0:NQ][3];
	dctx_t       cx_q  [0:NQ];

	assign rv[0] = in_trig.itm.rx;
	assign rv[1] = in_trig.itm.ry;
	assign rv[2] = in_trig.itm.rz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		cx_s1.zero  <= in_trig.itm.zero;
		cx_s1.theta <= in_trig.theta;
		cx_s1.ch    <= in_trig.ch;
		cx_q[0]     <= cx_s1;
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic [63:0] ab;

		assign ab = p_s1[i][63] ? $unsigned(-p_s1[i]) : $unsigned(p_s1[i]);

		always_ff @(posedge clk) begin
			p_s1[i]     <= in_trig.sh * rv[i];
			neg_q[0][i] <= p_s1[i][63];
			mag_q[0][i] <= ab[62:0];
			rem_q[0][i] <= ab[62:31];
			quo_q[0][i] <= '0;
		end

		for (genvar j = 0; j < NQ; j++) begin : g_bit
			logic [32:0] cur;
			logic        ge;

			assign cur = {rem_q[j][i], mag_q[j][i][NQ-1-j]};
			assign ge  = (cur >= {1'b0, cx_q[j].theta});

			always_ff @(posedge clk) begin
				rem_q[j+1][i] <= ge ? 32'(cur - {1'b0, cx_q[j].theta}) : cur[31:0];
				quo_q[j+1][i] <= {quo_q[j][i][29:0], ge};
				mag_q[j+1][i] <= mag_q[j][i];
				neg_q[j+1][i] <= neg_q[j][i];
			end
		end
	end

	for (genvar j = 0; j < NQ; j++) begin : g_ctx
		always_ff @(posedge clk) begin
			cx_q[j+1] <= cx_q[j];
		end
	end

	always_ff @(posedge clk) begin
		if (cx_q[NQ].zero) begin
			quat_w <= qem_pkg::Q30_ONE;
			quat_x <= '0;
			quat_y <= '0;
			quat_z <= '0;
		end else begin
			quat_w <= cx_q[NQ].ch;
			quat_x <= neg_q[NQ][0] ? -$signed({1'b0, quo_q[NQ][0]}) : $signed({1'b0, quo_q[NQ][0]});
			quat_y <= neg_q[NQ][1] ? -$signed({1'b0, quo_q[NQ][1]}) : $signed({1'b0, quo_q[NQ][1]});
			quat_z <= neg_q[NQ][2] ? -$signed({1'b0, quo_q[NQ][2]}) : $signed({1'b0, quo_q[NQ][2]});
		end
	end

	assign done = vld_q[LAT-1];

endmodule

// ===== hw/rtl/quaternion_exponential_map_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_exponential_map_core
// Rotation vector (Q3.28) to unit quaternion (Q1.30) by the exponential map.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------
//   command  | start in, busy out | rot_x, rot_y, rot_z
//   result   | done out           | quat_w, quat_x, quat_y, quat_z
//
// One item is accepted every cycle; the back end is fully pipelined.
// The done strobe rises once the item has passed the queue, the square root
// (32 root stages), the sine/cosine unit (27 Horner stages) and the dividers
// (31 quotient stages).
// Reset clears the queue and all valid flags; payload registers are not reset.
// The result receiver cannot stall, so the back end never holds an item.
// ----------------------------------------------------------------------------
module quaternion_exponential_map_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] rot_x,
	input  logic signed [31:0] rot_y,
	input  logic signed [31:0] rot_z,
	output logic               done,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z
);

	logic           f_valid;
	qem_pkg::item_t f_item;
	logic           n_valid;
	qem_pkg::norm_t n_norm;
	logic           t_valid;
	qem_pkg::trig_t t_trig;

	qem_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.rot_x     (rot_x),
		.rot_y     (rot_y),
		.rot_z     (rot_z),
		.out_valid (f_valid),
		.out_item  (f_item)
	);

	qem_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_item   (f_item),
		.out_valid (n_valid),
		.out_norm  (n_norm)
	);

	qem_sincos u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (n_valid),
		.in_norm   (n_norm),
		.out_valid (t_valid),
		.out_trig  (t_trig)
	);

	qem_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (t_valid),
		.in_trig  (t_trig),
		.done     (done),
		.quat_w   (quat_w),
		.quat_x   (quat_x),
		.quat_y   (quat_y),
		.quat_z   (quat_z)
	);

endmodule
